// ----- rtl/scss_pkg.sv -----
// ============================================================================
// scss_pkg: shared types and constants of the COO submatrix select unit
// Holds the command and mode codes, the sizes and the control structs.
// ============================================================================
package scss_pkg;

    // Sizes
    localparam int LIST_DEPTH = 1024;
    localparam int LIST_AW    = 10;
    localparam int CNT_W      = 11;
    localparam int RUN_CAP    = 64;
    localparam int HIT_AW     = 6;
    localparam int CAP_W      = 7;
    localparam int PROD_W     = 22;
    localparam int IDX_W      = 16;
    localparam int VAL_W      = 64;
    localparam int PADDR_W    = 5;

    // Input command codes
    localparam logic [1:0] CMD_LOAD_ROW = 2'd0;
    localparam logic [1:0] CMD_LOAD_COL = 2'd1;
    localparam logic [1:0] CMD_NONZERO  = 2'd2;

    // Axis mode codes
    localparam logic [1:0] MODE_ALL  = 2'd0;
    localparam logic [1:0] MODE_ASC  = 2'd1;
    localparam logic [1:0] MODE_DESC = 2'd2;
    localparam logic [1:0] MODE_LIST = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_ROW_MODE  = 3'd0;
    localparam logic [2:0] REG_COL_MODE  = 3'd1;
    localparam logic [2:0] REG_ROW_FIRST = 3'd2;
    localparam logic [2:0] REG_ROW_LAST  = 3'd3;
    localparam logic [2:0] REG_COL_FIRST = 3'd4;
    localparam logic [2:0] REG_COL_LAST  = 3'd5;
    localparam logic [2:0] REG_ROW_COUNT = 3'd6;
    localparam logic [2:0] REG_COL_COUNT = 3'd7;

    typedef struct packed {
        logic [1:0]       row_mode;
        logic [1:0]       col_mode;
        logic [IDX_W-1:0] row_first;
        logic [IDX_W-1:0] row_last;
        logic [IDX_W-1:0] col_first;
        logic [IDX_W-1:0] col_last;
        logic [CNT_W-1:0] row_count;
        logic [CNT_W-1:0] col_count;
    } cfg_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;
        logic setup;
        logic scan;
        logic mul;
        logic emit_ld;
        logic emit_adv;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic nz_item;
        logic scan_done;
        logic total_zero;
        logic last_hit;
    } dp_sts_t;

endpackage

// ----- rtl/scss_ram.sv -----
// ============================================================================
// scss_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
module scss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/scss_csr.sv -----
// ============================================================================
// scss_csr: configuration registers
// APB-style write and read of the eight selection registers.
// ============================================================================
module scss_csr (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [scss_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output scss_pkg::cfg_t              cfg
);
    import scss_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] idx;
    logic       wr;

    assign idx    = paddr[PADDR_W-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                REG_ROW_MODE:  cfg_next.row_mode  = pwdata[1:0];
                REG_COL_MODE:  cfg_next.col_mode  = pwdata[1:0];
                REG_ROW_FIRST: cfg_next.row_first = pwdata[IDX_W-1:0];
                REG_ROW_LAST:  cfg_next.row_last  = pwdata[IDX_W-1:0];
                REG_COL_FIRST: cfg_next.col_first = pwdata[IDX_W-1:0];
                REG_COL_LAST:  cfg_next.col_last  = pwdata[IDX_W-1:0];
                REG_ROW_COUNT: cfg_next.row_count = pwdata[CNT_W-1:0];
                REG_COL_COUNT: cfg_next.col_count = pwdata[CNT_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read decode.
    always_comb
    begin
        unique case (idx)
            REG_ROW_MODE:  prdata = {30'd0, cfg_reg.row_mode};
            REG_COL_MODE:  prdata = {30'd0, cfg_reg.col_mode};
            REG_ROW_FIRST: prdata = {16'd0, cfg_reg.row_first};
            REG_ROW_LAST:  prdata = {16'd0, cfg_reg.row_last};
            REG_COL_FIRST: prdata = {16'd0, cfg_reg.col_first};
            REG_COL_LAST:  prdata = {16'd0, cfg_reg.col_last};
            REG_ROW_COUNT: prdata = {21'd0, cfg_reg.row_count};
            REG_COL_COUNT: prdata = {21'd0, cfg_reg.col_count};
            default:       prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/scss_dp.sv -----
// ============================================================================
// scss_dp: datapath of the COO submatrix select unit
// Selection lists, list scan, hit buffers, run sizing and output registers.
// ============================================================================
module scss_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  scss_pkg::cfg_t              cfg,
    input  scss_pkg::dp_cmd_t           cmd,
    output scss_pkg::dp_sts_t           sts,
    input  logic [1:0]                  command,
    input  logic [scss_pkg::LIST_AW-1:0] position,
    input  logic [scss_pkg::IDX_W-1:0]  source_index,
    input  logic [scss_pkg::IDX_W-1:0]  row_index,
    input  logic [scss_pkg::IDX_W-1:0]  col_index,
    input  logic [scss_pkg::VAL_W-1:0]  value,
    output logic [scss_pkg::IDX_W-1:0]  out_row,
    output logic [scss_pkg::IDX_W-1:0]  out_col,
    output logic [scss_pkg::VAL_W-1:0]  out_value,
    output logic                        last,
    output logic                        truncated
);
    import scss_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);
    localparam logic [CNT_W-1:0] CAP_CNT   = CNT_W'(RUN_CAP);
    localparam logic [CAP_W-1:0] CAP_SMALL = CAP_W'(RUN_CAP);

    // Latched item
    logic [IDX_W-1:0]  ri_reg, ci_reg;
    logic [VAL_W-1:0]  val_reg;
    // Scan state
    logic [CNT_W-1:0]  issue_reg;
    logic              pipe_valid_reg;
    logic [LIST_AW-1:0] pipe_pos_reg;
    logic [CNT_W-1:0]  nr_reg, nc_reg;
    logic [PROD_W-1:0] prod_reg;
    // Emit counters
    logic [HIT_AW-1:0] a_reg, b_reg;
    logic [CAP_W-1:0]  k_reg;
    // Output registers
    logic [IDX_W-1:0]  out_row_reg, out_col_reg;
    logic [VAL_W-1:0]  out_value_reg;
    logic              out_last_reg, out_trunc_reg;

    logic [IDX_W-1:0]  row_list_rd, col_list_rd, row_hit_rd, col_hit_rd;
    logic              row_load, col_load;
    logic [CNT_W-1:0]  row_lim, col_lim, row_len, col_len, scan_len;
    logic [IDX_W-1:0]  row_lo, row_hi, col_lo, col_hi;
    logic              row_nl_match, col_nl_match;
    logic [IDX_W-1:0]  row_nl_val, col_nl_val;
    logic              row_scan_hit, col_scan_hit;
    logic              row_hw_en, col_hw_en;
    logic [HIT_AW-1:0] row_hw_addr, col_hw_addr;
    logic [IDX_W-1:0]  row_hw_data, col_hw_data;
    logic [CAP_W-1:0]  rn, cn, emit;
    logic              trunc;

    // List loads.
    assign row_load = cmd.take && (command == CMD_LOAD_ROW);
    assign col_load = cmd.take && (command == CMD_LOAD_COL);

    scss_ram #(.WIDTH(IDX_W), .DEPTH(LIST_DEPTH)) u_row_list (
        .clk     (clk),
        .wr_en   (row_load),
        .wr_addr (position),
        .wr_data (source_index),
        .rd_addr (issue_reg[LIST_AW-1:0]),
        .rd_data (row_list_rd)
    );

    scss_ram #(.WIDTH(IDX_W), .DEPTH(LIST_DEPTH)) u_col_list (
        .clk     (clk),
        .wr_en   (col_load),
        .wr_addr (position),
        .wr_data (source_index),
        .rd_addr (issue_reg[LIST_AW-1:0]),
        .rd_data (col_list_rd)
    );

    // Scan length: the longer of the lists that are in use.
    assign row_lim  = (cfg.row_count > DEPTH_CNT) ? DEPTH_CNT : cfg.row_count;
    assign col_lim  = (cfg.col_count > DEPTH_CNT) ? DEPTH_CNT : cfg.col_count;
    assign row_len  = (cfg.row_mode == MODE_LIST) ? row_lim : '0;
    assign col_len  = (cfg.col_mode == MODE_LIST) ? col_lim : '0;
    assign scan_len = (row_len > col_len) ? row_len : col_len;

    // Single-match modes for rows.
    assign row_lo = (cfg.row_first < cfg.row_last) ? cfg.row_first : cfg.row_last;
    assign row_hi = (cfg.row_first < cfg.row_last) ? cfg.row_last : cfg.row_first;
    always_comb
    begin
        case (cfg.row_mode)
            MODE_ALL:
            begin
                row_nl_match = 1'b1;
                row_nl_val   = ri_reg;
            end
            MODE_ASC:
            begin
                row_nl_match = (ri_reg >= row_lo) && (ri_reg <= row_hi);
                row_nl_val   = ri_reg - cfg.row_first;
            end
            MODE_DESC:
            begin
                row_nl_match = (ri_reg >= row_lo) && (ri_reg <= row_hi);
                row_nl_val   = cfg.row_first - ri_reg;
            end
            default:
            begin
                row_nl_match = 1'b0;
                row_nl_val   = ri_reg;
            end
        endcase
    end

    // Single-match modes for columns.
    assign col_lo = (cfg.col_first < cfg.col_last) ? cfg.col_first : cfg.col_last;
    assign col_hi = (cfg.col_first < cfg.col_last) ? cfg.col_last : cfg.col_first;
    always_comb
    begin
        case (cfg.col_mode)
            MODE_ALL:
            begin
                col_nl_match = 1'b1;
                col_nl_val   = ci_reg;
            end
            MODE_ASC:
            begin
                col_nl_match = (ci_reg >= col_lo) && (ci_reg <= col_hi);
                col_nl_val   = ci_reg - cfg.col_first;
            end
            MODE_DESC:
            begin
                col_nl_match = (ci_reg >= col_lo) && (ci_reg <= col_hi);
                col_nl_val   = cfg.col_first - ci_reg;
            end
            default:
            begin
                col_nl_match = 1'b0;
                col_nl_val   = ci_reg;
            end
        endcase
    end

    // List compare stage, one position per cycle.
    assign row_scan_hit = cmd.scan && pipe_valid_reg && (cfg.row_mode == MODE_LIST)
                          && ({1'b0, pipe_pos_reg} < row_lim) && (row_list_rd == ri_reg);
    assign col_scan_hit = cmd.scan && pipe_valid_reg && (cfg.col_mode == MODE_LIST)
                          && ({1'b0, pipe_pos_reg} < col_lim) && (col_list_rd == ci_reg);

    // Hit buffer writes.
    assign row_hw_en   = cmd.setup ? row_nl_match : (row_scan_hit && (nr_reg < CAP_CNT));
    assign row_hw_addr = cmd.setup ? '0 : nr_reg[HIT_AW-1:0];
    assign row_hw_data = cmd.setup ? row_nl_val : IDX_W'(pipe_pos_reg);
    assign col_hw_en   = cmd.setup ? col_nl_match : (col_scan_hit && (nc_reg < CAP_CNT));
    assign col_hw_addr = cmd.setup ? '0 : nc_reg[HIT_AW-1:0];
    assign col_hw_data = cmd.setup ? col_nl_val : IDX_W'(pipe_pos_reg);

    scss_ram #(.WIDTH(IDX_W), .DEPTH(RUN_CAP)) u_row_hits (
        .clk     (clk),
        .wr_en   (row_hw_en),
        .wr_addr (row_hw_addr),
        .wr_data (row_hw_data),
        .rd_addr (a_reg),
        .rd_data (row_hit_rd)
    );

    scss_ram #(.WIDTH(IDX_W), .DEPTH(RUN_CAP)) u_col_hits (
        .clk     (clk),
        .wr_en   (col_hw_en),
        .wr_addr (col_hw_addr),
        .wr_data (col_hw_data),
        .rd_addr (b_reg),
        .rd_data (col_hit_rd)
    );

    // Run sizing.
    assign rn    = (nr_reg > CAP_CNT) ? CAP_SMALL : nr_reg[CAP_W-1:0];
    assign cn    = (nc_reg > CAP_CNT) ? CAP_SMALL : nc_reg[CAP_W-1:0];
    assign trunc = (prod_reg > PROD_W'(RUN_CAP));
    assign emit  = trunc ? CAP_SMALL : prod_reg[CAP_W-1:0];

    // Item latch.
    always_ff @(posedge clk)
    begin
        if (cmd.take && (command == CMD_NONZERO))
        begin
            ri_reg  <= row_index;
            ci_reg  <= col_index;
            val_reg <= value;
        end
    end

    // Scan counters and match counts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg      <= '0;
            pipe_valid_reg <= 1'b0;
            nr_reg         <= '0;
            nc_reg         <= '0;
        end
        else if (cmd.setup)
        begin
            issue_reg      <= '0;
            pipe_valid_reg <= 1'b0;
            nr_reg         <= row_nl_match ? CNT_W'(1) : '0;
            nc_reg         <= col_nl_match ? CNT_W'(1) : '0;
        end
        else if (cmd.scan)
        begin
            pipe_valid_reg <= (issue_reg < scan_len);
            if (issue_reg < scan_len)
            begin
                issue_reg <= issue_reg + CNT_W'(1);
            end
            if (row_scan_hit)
            begin
                nr_reg <= nr_reg + CNT_W'(1);
            end
            if (col_scan_hit)
            begin
                nc_reg <= nc_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_pos_reg <= issue_reg[LIST_AW-1:0];
    end

    // Product and emit counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
            k_reg    <= '0;
        end
        else if (cmd.mul)
        begin
            prod_reg <= nr_reg * nc_reg;
            a_reg    <= '0;
            b_reg    <= '0;
            k_reg    <= '0;
        end
        else if (cmd.emit_adv)
        begin
            k_reg <= k_reg + CAP_W'(1);
            if (({1'b0, b_reg} + CAP_W'(1)) == cn)
            begin
                b_reg <= '0;
                a_reg <= a_reg + HIT_AW'(1);
            end
            else
            begin
                b_reg <= b_reg + HIT_AW'(1);
            end
        end
    end

    // Output registers.
    always_ff @(posedge clk)
    begin
        if (cmd.emit_ld)
        begin
            out_row_reg   <= row_hit_rd;
            out_col_reg   <= col_hit_rd;
            out_value_reg <= val_reg;
            out_last_reg  <= (k_reg == (emit - CAP_W'(1)));
            out_trunc_reg <= trunc;
        end
    end

    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign last      = out_last_reg;
    assign truncated = out_trunc_reg;

    // Status.
    assign sts.nz_item    = (command == CMD_NONZERO);
    assign sts.scan_done  = (issue_reg >= scan_len) && !pipe_valid_reg;
    assign sts.total_zero = (prod_reg == '0) || (rn == '0);
    assign sts.last_hit   = out_last_reg;

endmodule

// ----- rtl/scss_ctrl.sv -----
// ============================================================================
// scss_ctrl: controller of the COO submatrix select unit
// Sequences item intake, list scan, run sizing and result emission.
// ============================================================================
module scss_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output scss_pkg::dp_cmd_t    cmd,
    input  scss_pkg::dp_sts_t    sts
);
    import scss_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_MUL,
        ST_CHECK,
        ST_RD,
        ST_LD,
        ST_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Next state.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && sts.nz_item)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:   state_next = ST_CHECK;
            ST_CHECK: state_next = sts.total_zero ? ST_IDLE : ST_RD;
            ST_RD:    state_next = ST_LD;
            ST_LD:
            begin
                state_next     = ST_HOLD;
                out_valid_next = 1'b1;
            end
            ST_HOLD:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = sts.last_hit ? ST_IDLE : ST_RD;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath commands.
    always_comb
    begin
        cmd          = '0;
        cmd.take     = in_valid && (state_reg == ST_IDLE);
        cmd.setup    = (state_reg == ST_SETUP);
        cmd.scan     = (state_reg == ST_SCAN);
        cmd.mul      = (state_reg == ST_MUL);
        cmd.emit_ld  = (state_reg == ST_LD);
        cmd.emit_adv = (state_reg == ST_HOLD) && !out_stall && !sts.last_hit;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/sparse_coo_submatrix_select_unit.sv -----
// ============================================================================
// sparse_coo_submatrix_select_unit: COO submatrix selection
// Maps sparse nonzeros into a selected submatrix, one axis mode per axis.
// ============================================================================
// Usage:
// The input channel (in_valid/in_stall) takes one beat per command: a row
// or column list load, or a nonzero to map. The output channel
// (out_valid/out_stall) returns one beat per result, row matches outer and
// column matches inner, with last on the final beat of a nonzero and
// truncated on every beat of a run that exceeded 64 results.
// A nonzero passes through setup, scan, multiply and check states, and
// each result through read, load and hold. With a list in use, the scan
// runs over the longer of the row and column list counts in use (up to 1024
// positions, one per cycle through the list RAM read port). One item is
// worked on at a time; in_stall stays high until its last result beat is
// taken. The configuration registers must be written over the APB port
// only while idle; the block itself does not enforce this.
// Reset clears the registers and the controller; the selection lists are
// not cleared and must be loaded before use. When the receiver stalls,
// the result beat holds until taken.
// ============================================================================
module sparse_coo_submatrix_select_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [scss_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    command,
    input  logic [scss_pkg::LIST_AW-1:0]  position,
    input  logic [scss_pkg::IDX_W-1:0]    source_index,
    input  logic [scss_pkg::IDX_W-1:0]    row_index,
    input  logic [scss_pkg::IDX_W-1:0]    col_index,
    input  logic [scss_pkg::VAL_W-1:0]    value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [scss_pkg::IDX_W-1:0]    out_row,
    output logic [scss_pkg::IDX_W-1:0]    out_col,
    output logic [scss_pkg::VAL_W-1:0]    out_value,
    output logic                          last,
    output logic                          truncated
);
    import scss_pkg::*;

    cfg_t    cfg;
    dp_cmd_t cmd;
    dp_sts_t sts;

    // Configuration registers.
    scss_csr u_csr (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Controller.
    scss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Datapath.
    scss_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .sts          (sts),
        .command      (command),
        .position     (position),
        .source_index (source_index),
        .row_index    (row_index),
        .col_index    (col_index),
        .value        (value),
        .out_row      (out_row),
        .out_col      (out_col),
        .out_value    (out_value),
        .last         (last),
        .truncated    (truncated)
    );

`ifndef SYNTHESIS
    // No new item is taken while a result beat is offered.
    a_no_take_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while a result is pending");

    // A nonzero blocks the input in the next cycle.
    a_nz_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (command == CMD_NONZERO)) |=> in_stall)
        else $error("input not blocked after a nonzero");

    // A taken last beat ends the run.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last) |=> !out_valid)
        else $error("result offered after the last beat");
`endif

endmodule

// ----- dv/sparse_coo_submatrix_select_unit_test.sv -----
// ============================================================================
// sparse_coo_submatrix_select_unit_test: COO submatrix select unit testbench
// Loads the selection lists and then sends nonzeros under a series of axis
// mode settings. A scoreboard predicts every result beat and checks the
// block's output beats in order, with random gaps and stalls on both sides.
// ============================================================================
module sparse_coo_submatrix_select_unit_test;

    import scss_pkg::*;

    // Unused command code, which the block ignores.
    localparam logic [1:0] CMD_RESERVED = 2'd3;
    // Number of leading list positions that are loaded and used.
    localparam int FILL_N = 32;

    // One expected or observed result beat.
    typedef struct {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] val;
        logic             is_last;
        logic             trunc;
    } entry_t;

    // Scoreboard: holds its own copy of the registers and selection lists.
    class submatrix_scoreboard;
        logic [1:0]       row_mode, col_mode;
        logic [IDX_W-1:0] row_first, row_last, col_first, col_last;
        logic [CNT_W-1:0] row_count, col_count;
        logic [IDX_W-1:0] row_list [LIST_DEPTH];
        logic [IDX_W-1:0] col_list [LIST_DEPTH];
        logic [IDX_W-1:0] row_hits [RUN_CAP];
        logic [IDX_W-1:0] col_hits [RUN_CAP];
        entry_t           pending_q [$];
        int               mismatches;

        function void set_reg(logic [2:0] idx, logic [31:0] d);
            case (idx)
                REG_ROW_MODE:  row_mode  = d[1:0];
                REG_COL_MODE:  col_mode  = d[1:0];
                REG_ROW_FIRST: row_first = d[15:0];
                REG_ROW_LAST:  row_last  = d[15:0];
                REG_COL_FIRST: col_first = d[15:0];
                REG_COL_LAST:  col_last  = d[15:0];
                REG_ROW_COUNT: row_count = d[CNT_W-1:0];
                REG_COL_COUNT: col_count = d[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Maps one coordinate; returns the full match count, keeps the first 64.
        function int map_axis(bit is_row, logic [IDX_W-1:0] x);
            logic [1:0]       mode;
            logic [IDX_W-1:0] first, lst, lo, hi, w;
            int               lim, n;
            mode  = is_row ? row_mode : col_mode;
            first = is_row ? row_first : col_first;
            lst   = is_row ? row_last : col_last;
            lim   = is_row ? int'(row_count) : int'(col_count);
            lo    = (first < lst) ? first : lst;
            hi    = (first < lst) ? lst : first;
            n     = 0;
            w     = '0;
            case (mode)
                MODE_ALL:
                begin
                    w = x;
                    n = 1;
                end
                MODE_ASC:
                begin
                    if (x >= lo && x <= hi)
                    begin
                        w = x - first;
                        n = 1;
                    end
                end
                MODE_DESC:
                begin
                    if (x >= lo && x <= hi)
                    begin
                        w = first - x;
                        n = 1;
                    end
                end
                default:
                begin
                    if (lim > LIST_DEPTH) lim = LIST_DEPTH;
                    for (int p = 0; p < lim; p++)
                    begin
                        if ((is_row ? row_list[p] : col_list[p]) == x)
                        begin
                            if (n < RUN_CAP)
                            begin
                                if (is_row) row_hits[n] = p[IDX_W-1:0];
                                else col_hits[n] = p[IDX_W-1:0];
                            end
                            n++;
                        end
                    end
                end
            endcase
            if (mode != MODE_LIST && n == 1)
            begin
                if (is_row) row_hits[0] = w;
                else col_hits[0] = w;
            end
            return n;
        endfunction

        // Notes an accepted input beat and queues the results it causes.
        function void note_input(logic [1:0] cmd, logic [LIST_AW-1:0] pos,
                                 logic [IDX_W-1:0] src, logic [IDX_W-1:0] ri,
                                 logic [IDX_W-1:0] ci, logic [VAL_W-1:0] val);
            int     nr, nc, total, emit, k;
            entry_t e;
            if (cmd == CMD_LOAD_ROW) row_list[pos] = src;
            else if (cmd == CMD_LOAD_COL) col_list[pos] = src;
            else if (cmd == CMD_NONZERO)
            begin
                nr    = map_axis(1'b1, ri);
                nc    = map_axis(1'b0, ci);
                total = nr * nc;
                emit  = (total > RUN_CAP) ? RUN_CAP : total;
                k     = 0;
                for (int a = 0; a < nr && a < RUN_CAP && k < emit; a++)
                begin
                    for (int b = 0; b < nc && b < RUN_CAP && k < emit; b++)
                    begin
                        e.row     = row_hits[a];
                        e.col     = col_hits[b];
                        e.val     = val;
                        e.is_last = (k + 1 == emit);
                        e.trunc   = (total > RUN_CAP);
                        pending_q.insert(pending_q.size(), e);
                        k++;
                    end
                end
            end
        endfunction

        // Compares one result beat with the oldest expectation.
        function void check_result(entry_t got);
            entry_t exp_e;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result row=%h col=%h value=%h",
                             got.row, got.col, got.val);
                return;
            end
            exp_e = pending_q.pop_front();
            if (exp_e.row !== got.row || exp_e.col !== got.col ||
                exp_e.val !== got.val || exp_e.is_last !== got.is_last ||
                exp_e.trunc !== got.trunc)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: expected %h %h %h last=%b trunc=%b, ",
                              "got %h %h %h last=%b trunc=%b"},
                             exp_e.row, exp_e.col, exp_e.val, exp_e.is_last,
                             exp_e.trunc, got.row, got.col, got.val,
                             got.is_last, got.trunc);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [1:0]           command = CMD_LOAD_ROW;
    logic [LIST_AW-1:0]   position = '0;
    logic [IDX_W-1:0]     source_index = '0, row_index = '0, col_index = '0;
    logic [VAL_W-1:0]     value = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [IDX_W-1:0]     out_row, out_col;
    logic [VAL_W-1:0]     out_value;
    logic                 last, truncated;

    submatrix_scoreboard sb = new();
    bit                  idle_on = 1'b1;
    int                  cycle_count = 0;
    int                  stall_left = 0;

    sparse_coo_submatrix_select_unit uut (.*);

    always #10 clk = ~clk;

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: checks each taken result beat, then stalls at random while gaps are on.
    always @(posedge clk)
    begin
        entry_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.row     = out_row;
            got.col     = out_col;
            got.val     = out_value;
            got.is_last = last;
            got.trunc   = truncated;
            sb.check_result(got);
            stall_left = idle_on ? $urandom_range(0, 10) : 0;
        end
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Register write: setup phase, access phase, then back to idle.
    task automatic write_reg(logic [2:0] idx, logic [31:0] d);
        paddr   <= {idx, 2'b00};
        pwdata  <= d;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_reg(idx, d);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Sends one input beat after a random gap when gaps are on; returns at the accepting edge.
    task automatic send_beat(logic [1:0] cmd, logic [LIST_AW-1:0] pos,
                             logic [IDX_W-1:0] src, logic [IDX_W-1:0] ri,
                             logic [IDX_W-1:0] ci, logic [VAL_W-1:0] val);
        int gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        command      <= cmd;
        position     <= pos;
        source_index <= src;
        row_index    <= ri;
        col_index    <= ci;
        value        <= val;
        in_valid     <= 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_input(cmd, pos, src, ri, ci, val);
    endtask

    function automatic logic [63:0] rand_value();
        return {$urandom(), $urandom()};
    endfunction

    // Picks a list entry value: mostly small so that runs fan out.
    function automatic logic [IDX_W-1:0] pick_src();
        if ($urandom_range(0, 3) == 0) return IDX_W'($urandom_range(0, 65535));
        return IDX_W'($urandom_range(0, 3));
    endfunction

    // Picks a coordinate that usually matches under the current axis setting.
    function automatic logic [IDX_W-1:0] pick_index(bit is_row);
        logic [1:0]       mode;
        logic [IDX_W-1:0] f, l, lo, hi;
        mode = is_row ? sb.row_mode : sb.col_mode;
        f    = is_row ? sb.row_first : sb.col_first;
        l    = is_row ? sb.row_last : sb.col_last;
        lo   = (f < l) ? f : l;
        hi   = (f < l) ? l : f;
        if ($urandom_range(0, 9) == 0) return IDX_W'($urandom_range(0, 65535));
        case (mode)
            MODE_ALL:  return IDX_W'($urandom_range(0, 65535));
            MODE_LIST: return IDX_W'($urandom_range(0, 3));
            default:   return IDX_W'($urandom_range(lo, hi));
        endcase
    endfunction

    // Waits out the tail of the current work so that registers may change.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (1100) @(posedge clk);
    endtask

    // Stimulus.
    initial
    begin
        logic [31:0] cnt_pick [6];
        cnt_pick = '{0, 1, 5, 17, 31, 32};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats in the reset setting (all rows, all columns).
        send_beat(CMD_NONZERO, '0, '0, 16'h0000, 16'h0000, 64'h0);
        send_beat(CMD_NONZERO, '0, '0, 16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(CMD_NONZERO, '0, '0, 16'hFFFF, 16'h0000, 64'h8000_0000_0000_0001);
        send_beat(CMD_RESERVED, 10'h3FF, 16'hFFFF, 16'h1234, 16'h5678, rand_value());
        send_beat(CMD_NONZERO, '0, '0, 16'h0000, 16'hFFFF, rand_value());
        send_beat(CMD_LOAD_ROW, 10'h3FF, 16'hFFFF, '0, '0, '0);
        send_beat(CMD_LOAD_COL, 10'h3FF, 16'h0000, '0, '0, '0);

        // Fill the leading list positions; counts never reach past them.
        idle_on = 1'b0;
        for (int p = 0; p < FILL_N; p++)
        begin
            send_beat(CMD_LOAD_ROW, LIST_AW'(p), IDX_W'($urandom_range(0, 2)),
                      '0, '0, '0);
            send_beat(CMD_LOAD_COL, LIST_AW'(p), IDX_W'($urandom_range(0, 2)),
                      '0, '0, '0);
        end
        drain();

        // Phases of axis settings, the first few at the extremes.
        for (int ph = 0; ph < 14; ph++)
        begin
            idle_on = (ph % 4 != 3);
            case (ph)
                0:
                begin
                    write_reg(REG_ROW_MODE, 32'(MODE_ASC));
                    write_reg(REG_COL_MODE, 32'(MODE_DESC));
                    write_reg(REG_ROW_FIRST, 32'hFFFF);
                    write_reg(REG_ROW_LAST, 32'h0);
                    write_reg(REG_COL_FIRST, 32'h0);
                    write_reg(REG_COL_LAST, 32'hFFFF);
                end
                1:
                begin
                    write_reg(REG_ROW_MODE, 32'(MODE_LIST));
                    write_reg(REG_COL_MODE, 32'(MODE_LIST));
                    write_reg(REG_ROW_COUNT, 32'(FILL_N));
                    write_reg(REG_COL_COUNT, 32'd0);
                end
                2:
                begin
                    write_reg(REG_ROW_COUNT, 32'd1);
                    write_reg(REG_COL_COUNT, 32'(FILL_N));
                end
                default:
                begin
                    write_reg(REG_ROW_MODE, $urandom_range(0, 3));
                    write_reg(REG_COL_MODE, $urandom_range(0, 3));
                    write_reg(REG_ROW_FIRST, $urandom_range(0, 65535));
                    write_reg(REG_ROW_LAST, $urandom_range(0, 65535));
                    write_reg(REG_COL_FIRST, $urandom_range(0, 65535));
                    write_reg(REG_COL_LAST, $urandom_range(0, 65535));
                    write_reg(REG_ROW_COUNT, cnt_pick[$urandom_range(0, 5)]);
                    write_reg(REG_COL_COUNT, cnt_pick[$urandom_range(0, 5)]);
                end
            endcase

            // Mostly nonzeros, with a few list loads and unused commands.
            for (int i = 0; i < 8; i++)
            begin
                case ($urandom_range(0, 9))
                    0: send_beat(CMD_LOAD_ROW, LIST_AW'($urandom_range(0, FILL_N - 1)),
                                 pick_src(), '0, '0, '0);
                    1: send_beat(CMD_LOAD_COL, LIST_AW'($urandom_range(0, FILL_N - 1)),
                                 pick_src(), '0, '0, '0);
                    2: send_beat(CMD_RESERVED, LIST_AW'($urandom_range(0, 1023)),
                                 IDX_W'($urandom_range(0, 65535)),
                                 IDX_W'($urandom_range(0, 65535)),
                                 IDX_W'($urandom_range(0, 65535)), rand_value());
                    default: send_beat(CMD_NONZERO, LIST_AW'($urandom_range(0, 1023)),
                                       IDX_W'($urandom_range(0, 65535)),
                                       pick_index(1'b1), pick_index(1'b0),
                                       rand_value());
                endcase
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
